// File: rtl/ddft_pkg.sv
// Shared widths, defaults and twiddle table generator for the direct DFT core.
package ddft_pkg;

  localparam int DEF_POINTS = 64;
  localparam int MAX_POINTS = 64;
  localparam int SAMPLE_W   = 16;
  localparam int ACC_W      = 24;
  localparam int BIN_W      = 6;

  // Reciprocal scaling for the inverse transform: q = (u * RECIP) >> SCALE_SH
  localparam int SCALE_SH   = 31;
  localparam int RECIP_W    = 31;

  localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30    = 64'd1 << 30;

  // Taylor term divisors: (2n)(2n+1) for sine, (2n-1)(2n) for cosine
  localparam logic [63:0] SIN_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                          64'd110, 64'd156, 64'd210, 64'd272};
  localparam logic [63:0] COS_DIV [8] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                          64'd90, 64'd132, 64'd182, 64'd240};

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t cos_v;
    sample_t sin_v;
  } tw_t;

  // Round a non-negative Q30 value to Q1.15, clamped to 0 .. 32767.
  function automatic sample_t q30_to_q15(input logic signed [63:0] v);
    logic signed [63:0] vc;
    logic signed [63:0] r;
    vc = (v < 0) ? 64'sd0 : v;
    r  = (vc + 64'sd16384) >>> 15;
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end
    return SAMPLE_W'(r);
  endfunction

  // Twiddle entry for a 32-bit phase word p (top two bits give the quadrant).
  function automatic tw_t tw_entry(input logic [63:0] p);
    logic [1:0]         quad;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        ts;
    logic [63:0]        tc;
    logic signed [63:0] s;
    logic signed [63:0] c;
    sample_t            s15;
    sample_t            c15;
    tw_t                t;
    quad = p[31:30];
    r    = {34'd0, p[29:0]};
    x    = (r * HALFPI_Q30) >> 30;
    x2   = (x * x) >> 30;
    ts   = x;
    tc   = ONE_Q30;
    s    = signed'(x);
    c    = signed'(ONE_Q30);
    for (int n = 1; n <= 8; n++) begin
      ts = ((ts * x2) >> 30) / SIN_DIV[n-1];
      tc = ((tc * x2) >> 30) / COS_DIV[n-1];
      if (n % 2 == 1) begin
        s = s - signed'(ts);
        c = c - signed'(tc);
      end else begin
        s = s + signed'(ts);
        c = c + signed'(tc);
      end
    end
    s15 = q30_to_q15(s);
    c15 = q30_to_q15(c);
    unique case (quad)
      2'd0: begin t.cos_v = c15;  t.sin_v = s15;  end
      2'd1: begin t.cos_v = -s15; t.sin_v = c15;  end
      2'd2: begin t.cos_v = -c15; t.sin_v = -s15; end
      default: begin t.cos_v = s15; t.sin_v = -c15; end
    endcase
    return t;
  endfunction

  // Round a Q2.30 product back to Q1.15 (result spans -32768 .. 32768).
  function automatic logic signed [SAMPLE_W:0] rnd_q15(input logic signed [31:0] m);
    logic signed [31:0] t;
    t = (m + 32'sd16384) >>> 15;
    return t[SAMPLE_W:0];
  endfunction

endpackage

// File: rtl/direct_dft_forward_inverse_core.sv
// Direct DFT core: sample memory, one shared complex MAC, reciprocal scaler and output register.
//
//  Channel | Dir | Signals                                          | Transaction
//  --------+-----+--------------------------------------------------+----------------------------
//  in      | in  | in_valid/in_ready, in_sample_real, in_sample_imag | one Q1.15 complex sample
//  out     | out | out_valid/out_ready, out_bin_index, out_real,    | one Q9.15 frequency bin
//          |     | out_imag, out_block_last                         |
//  cfg     | in  | cfg_valid/cfg_ready, cfg_data                    | write of inverse_mode
//
//  Loading accepts one sample per cycle. After the last sample of a block the core
//  computes POINTS bins; each bin makes POINTS memory reads through the one read port
//  of the sample memory feeding the single complex MAC, then drains the pipeline and
//  takes a scaling step and an emit step. A stall on out_ready holds the core in the
//  emit step; the last bin may wait in the output register while loading of the next
//  block already proceeds. Reset is synchronous and active low; it clears control
//  state and inverse_mode. The sample memory is not reset: every entry is written
//  before a block is read.
module direct_dft_forward_inverse_core #(
  parameter int POINTS = ddft_pkg::DEF_POINTS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample input
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ddft_pkg::SAMPLE_W-1:0] in_sample_real,
  input  logic signed [ddft_pkg::SAMPLE_W-1:0] in_sample_imag,
  // bin output
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [ddft_pkg::BIN_W-1:0]   out_bin_index,
  output logic signed [ddft_pkg::ACC_W-1:0]   out_real,
  output logic signed [ddft_pkg::ACC_W-1:0]   out_imag,
  output logic                                out_block_last,
  // configuration write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_data
);

  localparam int AW     = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int SW     = ddft_pkg::SAMPLE_W;
  localparam int AccW   = ddft_pkg::ACC_W;
  localparam int PRW    = AccW + ddft_pkg::RECIP_W;
  localparam int ShL    = ddft_pkg::SCALE_SH;
  localparam logic [AW-1:0] LAST_IDX = AW'(POINTS - 1);
  localparam logic [AW:0]   POINTS_W = (AW+1)'(POINTS);
  localparam logic [63:0]   RECIP_FULL =
    ((64'd1 << ddft_pkg::SCALE_SH) + 64'(POINTS) - 64'd1) / 64'(POINTS);
  localparam logic [ddft_pkg::RECIP_W-1:0] RECIP = RECIP_FULL[ddft_pkg::RECIP_W-1:0];
  localparam logic [AccW:0] HALF_N = (AccW+1)'(POINTS / 2);

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_MAC   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_SCALE = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  // ---------------------------------------------------------------------------
  // Twiddle table, built at elaboration from the phase of each index
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] tw_cos [POINTS];
  logic signed [SW-1:0] tw_sin [POINTS];

  for (genvar gk = 0; gk < POINTS; gk++) begin : g_tw
    localparam logic [63:0] PH = ((64'(gk) << 32) + 64'(POINTS / 2)) / 64'(POINTS);
    localparam ddft_pkg::tw_t TW = ddft_pkg::tw_entry(PH);
    assign tw_cos[gk] = TW.cos_v;
    assign tw_sin[gk] = TW.sin_v;
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  state_t          state_r, state_nxt;
  logic [AW-1:0]   load_cnt_r;   // samples stored in the current block
  logic [AW-1:0]   j_r;          // sample index being read
  logic [AW-1:0]   bin_r;        // bin being computed
  logic [AW-1:0]   k_r;          // (bin * j) mod POINTS, tracked incrementally
  logic [AW:0]     k_sum;
  logic [AW-1:0]   k_nxt;
  logic            inverse_mode_r;

  logic            in_acc;
  logic            out_load;
  logic            out_valid_r;

  // MAC pipeline
  logic                 p1_v_r, p1_last_r;
  logic signed [SW-1:0] p1_c_r, p1_d_r;
  logic [2*SW-1:0]      mem_q_r;
  logic                 p2_v_r, p2_last_r;
  logic signed [SW:0]   p2_ac_r, p2_bd_r, p2_ad_r, p2_bc_r;
  logic signed [AccW-1:0] acc_re_r, acc_im_r;

  // scaler
  logic [AccW:0]        xs_re, xs_im;
  logic [AccW-1:0]      u_re, u_im;
  logic [PRW-1:0]       scl_re_r, scl_im_r;
  logic                 sgn_re_r, sgn_im_r;
  logic [AccW-1:0]      q_re, q_im;

  // output register
  logic [ddft_pkg::BIN_W-1:0] out_bin_index_r;
  logic signed [AccW-1:0]     out_real_r, out_imag_r;
  logic                       out_block_last_r;

  // sample memory: {real, imag}; written while loading, read while computing
  logic [2*SW-1:0] mem [POINTS];

  assign in_ready  = (state_r == ST_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  assign k_sum = {1'b0, k_r} + {1'b0, bin_r};
  assign k_nxt = (k_sum >= POINTS_W) ? AW'(k_sum - POINTS_W) : k_sum[AW-1:0];

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && (load_cnt_r == LAST_IDX)) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (j_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // advance once the last product of the bin lands in the accumulators
        if (p2_v_r && p2_last_r) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = (bin_r == LAST_IDX) ? ST_LOAD : ST_MAC;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_LOAD;
      load_cnt_r     <= '0;
      j_r            <= '0;
      bin_r          <= '0;
      k_r            <= '0;
      inverse_mode_r <= 1'b0;
      p1_v_r         <= 1'b0;
      p1_last_r      <= 1'b0;
      p2_v_r         <= 1'b0;
      p2_last_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        inverse_mode_r <= cfg_data;
      end

      if (in_acc) begin
        load_cnt_r <= (load_cnt_r == LAST_IDX) ? '0 : load_cnt_r + AW'(1);
      end

      // issue one read per cycle, stepping the twiddle index by the bin number
      if (state_r == ST_MAC) begin
        j_r <= j_r + AW'(1);
        k_r <= k_nxt;
      end else if (state_r != ST_DRAIN) begin
        j_r <= '0;
        k_r <= '0;
      end

      if (in_acc && (load_cnt_r == LAST_IDX)) begin
        bin_r <= '0;
      end else if (out_load && (bin_r != LAST_IDX)) begin
        bin_r <= bin_r + AW'(1);
      end

      p1_v_r    <= (state_r == ST_MAC);
      p1_last_r <= (state_r == ST_MAC) && (j_r == LAST_IDX);
      p2_v_r    <= p1_v_r;
      p2_last_r <= p1_v_r && p1_last_r;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample memory
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[load_cnt_r] <= {in_sample_real, in_sample_imag};
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MAC) begin
      mem_q_r <= mem[j_r];
    end
  end

  // ---------------------------------------------------------------------------
  // Complex MAC pipeline
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    // stage 1: twiddle fetch alongside the memory read
    p1_c_r <= tw_cos[k_r];
    p1_d_r <= inverse_mode_r ? tw_sin[k_r] : -tw_sin[k_r];
  end

  logic signed [SW-1:0] smp_a, smp_b;
  assign smp_a = signed'(mem_q_r[2*SW-1:SW]);
  assign smp_b = signed'(mem_q_r[SW-1:0]);

  always_ff @(posedge clk) begin
    // stage 2: four rounded Q1.15 products
    p2_ac_r <= ddft_pkg::rnd_q15(smp_a * p1_c_r);
    p2_bd_r <= ddft_pkg::rnd_q15(smp_b * p1_d_r);
    p2_ad_r <= ddft_pkg::rnd_q15(smp_a * p1_d_r);
    p2_bc_r <= ddft_pkg::rnd_q15(smp_b * p1_c_r);
  end

  always_ff @(posedge clk) begin
    // stage 3: accumulate; drop the old sums while loading and once the bin leaves for
    // the output register, and hold them while the emit step stalls
    if (out_load || state_r == ST_LOAD) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (p2_v_r) begin
      acc_re_r <= acc_re_r + {{(AccW-SW-1){p2_ac_r[SW]}}, p2_ac_r}
                           - {{(AccW-SW-1){p2_bd_r[SW]}}, p2_bd_r};
      acc_im_r <= acc_im_r + {{(AccW-SW-1){p2_ad_r[SW]}}, p2_ad_r}
                           + {{(AccW-SW-1){p2_bc_r[SW]}}, p2_bc_r};
    end
  end

  // ---------------------------------------------------------------------------
  // Inverse scaling: floor((sum + POINTS/2) / POINTS) by reciprocal multiply.
  // Negative values go through the one's complement so the floor stays exact.
  // ---------------------------------------------------------------------------
  assign xs_re = {acc_re_r[AccW-1], acc_re_r} + HALF_N;
  assign xs_im = {acc_im_r[AccW-1], acc_im_r} + HALF_N;
  assign u_re  = xs_re[AccW-1:0] ^ {AccW{xs_re[AccW]}};
  assign u_im  = xs_im[AccW-1:0] ^ {AccW{xs_im[AccW]}};

  always_ff @(posedge clk) begin
    if (state_r == ST_SCALE) begin
      scl_re_r <= PRW'(u_re) * PRW'(RECIP);
      scl_im_r <= PRW'(u_im) * PRW'(RECIP);
      sgn_re_r <= xs_re[AccW];
      sgn_im_r <= xs_im[AccW];
    end
  end

  assign q_re = scl_re_r[ShL +: AccW] ^ {AccW{sgn_re_r}};
  assign q_im = scl_im_r[ShL +: AccW] ^ {AccW{sgn_im_r}};

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bin_index_r  <= ddft_pkg::BIN_W'(bin_r);
      out_real_r       <= inverse_mode_r ? signed'(q_re) : acc_re_r;
      out_imag_r       <= inverse_mode_r ? signed'(q_im) : acc_im_r;
      out_block_last_r <= (bin_r == LAST_IDX);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bin_index  = out_bin_index_r;
  assign out_real       = out_real_r;
  assign out_imag       = out_imag_r;
  assign out_block_last = out_block_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (!p1_v_r && !p2_v_r))
    else $error("sample accepted while the MAC pipeline holds work");

  a_last_lands_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (p2_v_r && p2_last_r) |-> (state_r == ST_DRAIN))
    else $error("final product of a bin arrived outside the drain step");

  a_drain_to_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && p2_v_r && p2_last_r) |=> (state_r == ST_SCALE))
    else $error("bin sums not handed to the scaler");

  a_last_bin_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_block_last) |-> (out_bin_index == ddft_pkg::BIN_W'(POINTS - 1)))
    else $error("block_last flagged on a bin other than the final one");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the direct DFT core: random handshakes, forward and inverse blocks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef ddft_pkg::sample_t sample_t;

  localparam int POINTS         = ddft_pkg::DEF_POINTS;
  localparam int BIN_W          = ddft_pkg::BIN_W;
  localparam int ACC_W          = ddft_pkg::ACC_W;
  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 5;
  // The limit is several times the forced receiver hold-off, the longest quiet
  // stretch, plus one bin and the longest sender gap.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AT     = 100;   // bins seen before the forced hold-off
  localparam int SETTLE_CYCLES   = 8;     // extra cycles before a register write
  localparam int DRAIN_CYCLES    = 100;   // watch for stray bins at the end

  localparam sample_t S_MAX = 16'sh7FFF;
  localparam sample_t S_MIN = 16'sh8000;

  typedef longint unsigned u64_t;
  localparam u64_t HALF_PI_Q30 = 64'd1686629713;
  localparam u64_t ONE_Q30     = 64'd1 << 30;

  typedef enum logic {
    DIR_FORWARD = 1'b0,
    DIR_INVERSE = 1'b1
  } dft_dir_t;

  typedef enum logic [1:0] {
    QUAD_FIRST  = 2'd0,
    QUAD_SECOND = 2'd1,
    QUAD_THIRD  = 2'd2,
    QUAD_FOURTH = 2'd3
  } quadrant_t;

  // Stimulus styles for one block of samples.
  typedef enum int {
    BLK_DIRECTED,   // field extremes up front, random after
    BLK_RANDOM,     // full-range random with some extremes mixed in
    BLK_PEAK_POS,   // constant +max real, -max imag: largest bin sums
    BLK_PEAK_NEG    // constant -max real, +max imag
  } blk_kind_t;

  typedef struct packed {
    logic [BIN_W-1:0] idx;
    logic [ACC_W-1:0] re;
    logic [ACC_W-1:0] im;
    logic             last;
  } dft_bin_t;

  // Holds the sample block and the transform direction, and predicts the
  // bins of each completed block.
  class dft_scoreboard;
    sample_t  seq_re [POINTS];
    sample_t  seq_im [POINTS];
    longint   cos_tab [POINTS];
    longint   sin_tab [POINTS];
    int       fill;
    dft_dir_t dir;
    dft_bin_t bins_due [$];
    int       samples_seen;
    int       bins_checked;
    int       errors;

    function new();
      fill         = 0;
      dir          = DIR_FORWARD;
      samples_seen = 0;
      bins_checked = 0;
      errors       = 0;
      build_twiddles();
    endfunction

    // Round a non-negative Q30 value to Q1.15, clamped to 0 .. 32767.
    function longint q15_of(longint v);
      longint r;
      if (v < 0) begin
        v = 0;
      end
      r = (v + 16384) >>> 15;
      if (r > 32767) begin
        r = 32767;
      end
      return r;
    endfunction

    // Integer Taylor twiddles: phase word split into quadrant and angle.
    function void build_twiddles();
      u64_t      ph;
      u64_t      frac;
      u64_t      x;
      u64_t      x2;
      u64_t      ts;
      u64_t      tc;
      longint    s;
      longint    c;
      longint    s15;
      longint    c15;
      quadrant_t quad;
      for (int k = 0; k < POINTS; k++) begin
        ph   = ((u64_t'(k) << 32) + u64_t'(POINTS / 2)) / u64_t'(POINTS);
        quad = quadrant_t'(ph[31:30]);
        frac = ph & 64'h3FFF_FFFF;
        x    = (frac * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        ts   = x;
        tc   = ONE_Q30;
        s    = longint'(x);
        c    = longint'(ONE_Q30);
        for (int n = 1; n <= 8; n++) begin
          ts = ((ts * x2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
          tc = ((tc * x2) >> 30) / u64_t'((2 * n - 1) * (2 * n));
          if (n % 2 == 1) begin
            s -= longint'(ts);
            c -= longint'(tc);
          end else begin
            s += longint'(ts);
            c += longint'(tc);
          end
        end
        s15 = q15_of(s);
        c15 = q15_of(c);
        case (quad)
          QUAD_FIRST: begin
            cos_tab[k] = c15;
            sin_tab[k] = s15;
          end
          QUAD_SECOND: begin
            cos_tab[k] = -s15;
            sin_tab[k] = c15;
          end
          QUAD_THIRD: begin
            cos_tab[k] = -c15;
            sin_tab[k] = -s15;
          end
          default: begin
            cos_tab[k] = s15;
            sin_tab[k] = -c15;
          end
        endcase
      end
    endfunction

    // Q2.30 product back to Q1.15 with round-half-up.
    function longint round_q15(longint p);
      return (p + 16384) >>> 15;
    endfunction

    function longint floor_div(longint x, longint d);
      if (x >= 0) begin
        return x / d;
      end
      return -(((-x) - 1) / d) - 1;
    endfunction

    function void set_direction(dft_dir_t d);
      dir = d;
    endfunction

    // Store one accepted sample; on the last sample of a block queue all bins.
    // The direction in force at block completion is the one that counts.
    function void note_sample(sample_t re, sample_t im);
      longint   acc_re;
      longint   acc_im;
      longint   a;
      longint   b;
      longint   cw;
      longint   sw;
      int       k;
      dft_bin_t entry;
      seq_re[fill] = re;
      seq_im[fill] = im;
      fill++;
      samples_seen++;
      if (fill == POINTS) begin
        fill = 0;
        for (int i = 0; i < POINTS; i++) begin
          acc_re = 0;
          acc_im = 0;
          for (int j = 0; j < POINTS; j++) begin
            k  = (i * j) % POINTS;
            a  = seq_re[j];
            b  = seq_im[j];
            cw = cos_tab[k];
            sw = (dir == DIR_INVERSE) ? sin_tab[k] : -sin_tab[k];
            acc_re += round_q15(a * cw) - round_q15(b * sw);
            acc_im += round_q15(a * sw) + round_q15(b * cw);
          end
          if (dir == DIR_INVERSE) begin
            acc_re = floor_div(acc_re + POINTS / 2, POINTS);
            acc_im = floor_div(acc_im + POINTS / 2, POINTS);
          end
          entry.idx  = BIN_W'(i);
          entry.re   = ACC_W'(acc_re);
          entry.im   = ACC_W'(acc_im);
          entry.last = (i == POINTS - 1);
          bins_due.push_back(entry);
        end
      end
    endfunction

    function void check_bin(logic [BIN_W-1:0] idx, logic [ACC_W-1:0] re,
                            logic [ACC_W-1:0] im, logic last);
      dft_bin_t want;
      bins_checked++;
      if (bins_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected bin: idx %0d re %0d im %0d last %0b",
                 $time, idx, $signed(re), $signed(im), last);
        return;
      end
      want = bins_due.pop_front();
      if (want.idx !== idx || want.re !== re || want.im !== im || want.last !== last) begin
        errors++;
        $display("%0t: bin mismatch: expected idx %0d re %0d im %0d last %0b",
                 $time, want.idx, $signed(want.re), $signed(want.im), want.last);
        $display("%0t:                 actual idx %0d re %0d im %0d last %0b",
                 $time, idx, $signed(re), $signed(im), last);
      end
    endfunction

    function int pending();
      return bins_due.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  sample_t                 in_sample_real;
  sample_t                 in_sample_imag;
  logic                    out_valid;
  logic                    out_ready;
  logic [BIN_W-1:0]        out_bin_index;
  logic signed [ACC_W-1:0] out_real;
  logic signed [ACC_W-1:0] out_imag;
  logic                    out_block_last;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic                    cfg_data;

  dft_scoreboard sb;
  int            cfg_writes;
  int            idle_cycles = 0;
  bit            stall_done = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  direct_dft_forward_inverse_core #(
    .POINTS(POINTS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_real (in_sample_real),
    .in_sample_imag (in_sample_imag),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_bin_index  (out_bin_index),
    .out_real       (out_real),
    .out_imag       (out_imag),
    .out_block_last (out_block_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // Monitor: sample every handshake at the clock edge, before the drivers'
  // nonblocking updates land, and feed the scoreboard in edge order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.set_direction(dft_dir_t'(cfg_data));
      end
      if (in_valid && in_ready) begin
        sb.note_sample(in_sample_real, in_sample_imag);
      end
      if (out_valid && out_ready) begin
        sb.check_bin(out_bin_index, out_real, out_imag, out_block_last);
      end
    end
  end

  // Watchdog: end the run when no transaction of any channel moves for too long.
  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d bins still expected",
                 $time, idle_cycles, sb.pending());
        $display("direct_dft_forward_inverse_core test failed");
        $finish;
      end
    end
  end

  // Receiver: mix always-ready stretches, random per-cycle ready and short
  // stalls. Once, mid-run, hold off for a long stretch so the core backs up
  // while the sender keeps offering samples.
  initial begin
    int r;
    out_ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (!stall_done && sb.bins_checked >= HOLD_OFF_AT) begin
        stall_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (r < 20) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else if (r < 28) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) < 70);
        @(posedge clk);
      end
    end
  end

  // Sender gap: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t random_sample();
    if ($urandom_range(0, 99) < 85) begin
      return sample_t'($urandom_range(0, 65535));
    end
    case ($urandom_range(0, 3))
      0: return S_MAX;
      1: return S_MIN;
      2: return sample_t'(0);
      default: return sample_t'(-1);
    endcase
  endfunction

  function automatic void next_sample(input blk_kind_t kind, input int pos,
                                      output sample_t re, output sample_t im);
    re = random_sample();
    im = random_sample();
    case (kind)
      BLK_PEAK_POS: begin
        re = S_MAX;
        im = S_MIN;
      end
      BLK_PEAK_NEG: begin
        re = S_MIN;
        im = S_MAX;
      end
      BLK_DIRECTED: begin
        // Corner values first: full scale in both signs, zero, +/-1 LSB.
        case (pos)
          0:  begin re = S_MAX;         im = S_MAX;         end
          1:  begin re = S_MIN;         im = S_MIN;         end
          2:  begin re = S_MAX;         im = S_MIN;         end
          3:  begin re = S_MIN;         im = S_MAX;         end
          4:  begin re = 16'sd0;        im = 16'sd0;        end
          5:  begin re = -16'sd1;       im = -16'sd1;       end
          6:  begin re = 16'sd1;        im = -16'sd1;       end
          7:  begin re = 16'sd0;        im = S_MAX;         end
          8:  begin re = S_MIN;         im = 16'sd0;        end
          9:  begin re = 16'sd16384;    im = -16'sd16384;   end
          10: begin re = -16'sd1;       im = 16'sd1;        end
          11: begin re = 16'sd21845;    im = -16'sd21846;   end
          12: begin re = -16'sd32767;   im = 16'sd32767;    end
          default: ;
        endcase
      end
      default: ;
    endcase
  endfunction

  // Drive samples pos first .. first+count-1 of a block. Leave in_valid high
  // after the last one so a following run continues without a bubble.
  task automatic send_run(input blk_kind_t kind, input int first, input int count,
                          input bit steady);
    sample_t re;
    sample_t im;
    int      gap;
    for (int p = first; p < first + count; p++) begin
      next_sample(kind, p, re, im);
      in_valid       <= 1'b1;
      in_sample_real <= re;
      in_sample_imag <= im;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      if (!steady && p != first + count - 1) begin
        gap = pick_gap();
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // Drop in_valid and hold until every queued bin has come back, then give
  // the core a few more cycles before anything touches its register.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(input dft_dir_t d);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    in_valid       = 1'b0;
    in_sample_real = '0;
    in_sample_imag = '0;
    cfg_valid      = 1'b0;
    cfg_data       = DIR_FORWARD;
    rst_n          = 1'b0;
    cfg_writes     = 0;
    sb             = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Forward block from reset direction, corner samples first.
    send_run(BLK_DIRECTED, 0, POINTS, 1'b0);
    settle();

    // Inverse: full-scale block, then a random block back to back with no
    // sender gaps; the forced output hold-off lands in here.
    write_direction(DIR_INVERSE);
    send_run(BLK_PEAK_POS, 0, POINTS, 1'b0);
    send_run(BLK_RANDOM, 0, POINTS, 1'b1);
    settle();

    // Flip direction partway through loading a block: the block completes
    // forward, since only the setting at completion counts.
    send_run(BLK_PEAK_NEG, 0, 20, 1'b0);
    settle();
    write_direction(DIR_FORWARD);
    send_run(BLK_PEAK_NEG, 20, POINTS - 20, 1'b0);
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending() != 0) begin
      $display("%0t: %0d bins never arrived", $time, sb.pending());
    end
    $display("Sent %0d samples, checked %0d bins, %0d direction writes, %0d errors.",
             sb.samples_seen, sb.bins_checked, cfg_writes, sb.errors);
    $display("Blocks: corner values forward, full scale both ways, mid-block flip, long stall.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("direct_dft_forward_inverse_core test passed");
    end else begin
      $display("direct_dft_forward_inverse_core test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ddft_pkg.sv
rtl/direct_dft_forward_inverse_core.sv
tb/sv/tb_top.sv
